// ===== rtl/reservation_station_table_macros.svh =====
`ifndef RESERVATION_STATION_TABLE_MACROS_SVH
`define RESERVATION_STATION_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RSTAB_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("reservation station check failed");

// next-cycle implication
`define RSTAB_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("reservation station check failed");

`endif

// ===== rtl/rstab_pkg.sv =====
package rstab_pkg;

    localparam int TAG_BITS     = 6;
    localparam int VALUE_BITS   = 32;
    localparam int ROB_BITS     = 6;
    localparam int PAYLOAD_BITS = 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_BCAST  = 2'd2;
    localparam logic [1:0] REQ_SCAN   = 2'd3;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [PAYLOAD_BITS-1:0] op_payload;
        logic [TAG_BITS-1:0]     src1_tag;
        logic [VALUE_BITS-1:0]   src1_value;
        logic [TAG_BITS-1:0]     src2_tag;
        logic [VALUE_BITS-1:0]   src2_value;
        logic [ROB_BITS-1:0]     rob_id;
        logic [TAG_BITS-1:0]     bcast_tag;
        logic [VALUE_BITS-1:0]   bcast_value;
    } rstab_request_t;

    typedef struct packed {
        logic                    success;
        logic                    station_full;
        logic                    entry_valid;
        logic [PAYLOAD_BITS-1:0] out_payload;
        logic [VALUE_BITS-1:0]   out_src1;
        logic [VALUE_BITS-1:0]   out_src2;
        logic [ROB_BITS-1:0]     out_rob_index;
        logic                    last;
    } rstab_result_t;

    typedef struct packed {
        rstab_request_t req;
        logic           bcast_live;
        logic           ins_ready;
    } rstab_cmd_t;

endpackage

// ===== rtl/rstab_front.sv =====
module rstab_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  rstab_pkg::rstab_request_t request,
    input  logic                    pop,
    output logic                    busy,
    output logic                    cmd_valid,
    output rstab_pkg::rstab_cmd_t   cmd
);
    import rstab_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    rstab_cmd_t          queue_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                push;
    logic                do_pop;
    rstab_cmd_t          cls;

    assign busy      = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = start && !busy;
    assign do_pop    = pop && cmd_valid;

    // decode once on entry
    always_comb
    begin
        cls            = '0;
        cls.req        = request;
        cls.bcast_live = (request.req_type == REQ_BCAST) && (request.bcast_tag != '0);
        cls.ins_ready  = (request.src1_tag == '0) && (request.src2_tag == '0);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/rstab_table.sv =====
module rstab_table #(
    parameter int ENTRIES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  rstab_pkg::rstab_cmd_t  cmd,
    output logic                   pop,
    output logic                   result_valid,
    output rstab_pkg::rstab_result_t result
);
    import rstab_pkg::*;

    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic ST_EXEC = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                    state_reg, state_next;
    logic [ENTRIES-1:0]      busy_reg, busy_next;
    logic [ENTRIES-1:0]      ready_reg, ready_next;
    logic [ENTRIES-1:0]      mask_reg, mask_next;
    rstab_result_t           result_reg, result_next;
    logic                    result_valid_reg, result_valid_next;

    logic [TAG_BITS-1:0]     tag1_reg [ENTRIES];
    logic [TAG_BITS-1:0]     tag2_reg [ENTRIES];
    logic [VALUE_BITS-1:0]   op1_reg  [ENTRIES];
    logic [VALUE_BITS-1:0]   op2_reg  [ENTRIES];
    logic [PAYLOAD_BITS-1:0] pay_reg  [ENTRIES];
    logic [ROB_BITS-1:0]     rob_reg  [ENTRIES];

    logic [ENTRIES-1:0]      rob_match;
    logic [ENTRIES-1:0]      hit1;
    logic [ENTRIES-1:0]      hit2;
    logic [ENTRIES-1:0]      scan_src;
    logic [ENTRIES-1:0]      scan_rest;
    logic [IDX_BITS-1:0]     ins_idx;
    logic [IDX_BITS-1:0]     rem_idx;
    logic [IDX_BITS-1:0]     pick_idx;
    logic                    ins_hit;
    logic                    rem_hit;
    logic                    ins_we;
    logic                    bcast_we;
    logic                    scan_step;

    assign pop = cmd_valid && (state_reg == ST_EXEC);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rob_match[i] = busy_reg[i] && (rob_reg[i] == cmd.req.rob_id);
            hit1[i]      = busy_reg[i] && (tag1_reg[i] == cmd.req.bcast_tag);
            hit2[i]      = busy_reg[i] && (tag2_reg[i] == cmd.req.bcast_tag);
        end
    end

    // lowest-index priority encoders
    always_comb
    begin
        ins_idx  = '0;
        rem_idx  = '0;
        pick_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                ins_idx = IDX_BITS'(i);
            end
            if (rob_match[i])
            begin
                rem_idx = IDX_BITS'(i);
            end
            if (scan_src[i])
            begin
                pick_idx = IDX_BITS'(i);
            end
        end
    end

    assign ins_hit   = !(&busy_reg);
    assign rem_hit   = |rob_match;
    assign scan_src  = (state_reg == ST_SCAN) ? mask_reg : (busy_reg & ready_reg);
    assign scan_rest = scan_src & ~(ENTRIES'(1) << pick_idx);
    assign scan_step = (state_reg == ST_SCAN) || (pop && (cmd.req.req_type == REQ_SCAN));
    assign ins_we    = pop && (cmd.req.req_type == REQ_INSERT) && ins_hit;
    assign bcast_we  = pop && cmd.bcast_live;

    always_comb
    begin
        state_next        = state_reg;
        busy_next         = busy_reg;
        ready_next        = ready_reg;
        mask_next         = mask_reg;
        result_next       = '0;
        result_valid_next = 1'b0;

        if (pop)
        begin
            result_valid_next = 1'b1;
            result_next.last  = 1'b1;
            case (cmd.req.req_type)
                REQ_INSERT:
                begin
                    result_next.success = ins_hit;
                    if (ins_hit)
                    begin
                        busy_next[ins_idx]  = 1'b1;
                        ready_next[ins_idx] = cmd.ins_ready;
                    end
                end
                REQ_REMOVE:
                begin
                    result_next.success = rem_hit;
                    if (rem_hit)
                    begin
                        busy_next[rem_idx] = 1'b0;
                    end
                end
                REQ_BCAST:
                begin
                    if (cmd.bcast_live)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (busy_reg[i] && (hit1[i] || tag1_reg[i] == '0)
                                && (hit2[i] || tag2_reg[i] == '0))
                            begin
                                ready_next[i] = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (scan_step)
        begin
            result_valid_next = 1'b1;
            result_next.last  = 1'b1;
            if (scan_src != '0)
            begin
                result_next.entry_valid   = 1'b1;
                result_next.out_payload   = pay_reg[pick_idx];
                result_next.out_src1      = op1_reg[pick_idx];
                result_next.out_src2      = op2_reg[pick_idx];
                result_next.out_rob_index = rob_reg[pick_idx];
                result_next.last          = (scan_rest == '0);
                mask_next                 = scan_rest;
                state_next                = (scan_rest == '0) ? ST_EXEC : ST_SCAN;
            end
        end

        result_next.station_full = &busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_EXEC;
            busy_reg         <= '0;
            ready_reg        <= '0;
            mask_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            busy_reg         <= busy_next;
            ready_reg        <= ready_next;
            mask_reg         <= mask_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (ins_we && (ins_idx == IDX_BITS'(i)))
            begin
                tag1_reg[i] <= cmd.req.src1_tag;
                tag2_reg[i] <= cmd.req.src2_tag;
                op1_reg[i]  <= cmd.req.src1_value;
                op2_reg[i]  <= cmd.req.src2_value;
                pay_reg[i]  <= cmd.req.op_payload;
                rob_reg[i]  <= cmd.req.rob_id;
            end
            else if (bcast_we)
            begin
                if (hit1[i])
                begin
                    tag1_reg[i] <= '0;
                    op1_reg[i]  <= cmd.req.bcast_value;
                end
                if (hit2[i])
                begin
                    tag2_reg[i] <= '0;
                    op2_reg[i]  <= cmd.req.bcast_value;
                end
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/reservation_station_table.sv =====
// First result of a transaction: queue entry, then the result register.
// Insert, remove and broadcast: sustained one per cycle while no ready scan runs.
// Ready scan: one result per ready entry (a single result when none).
// A two-deep command queue absorbs scans; busy is high only while it is full.
// Async active-low reset empties the queue and clears busy and ready bits.
module reservation_station_table #(
    parameter int ENTRIES = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  rstab_pkg::rstab_request_t request,
    output logic                     busy,
    output logic                     result_valid,
    output rstab_pkg::rstab_result_t result
);
    import rstab_pkg::*;

    rstab_cmd_t cmd;
    logic       cmd_valid;
    logic       pop;

    rstab_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .pop       (pop),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    rstab_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== rtl/rstab_checker.sv =====
`include "reservation_station_table_macros.svh"

module rstab_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     result_valid,
    input  rstab_pkg::rstab_result_t result
);
    import rstab_pkg::*;

    logic plain_data_zero;

    assign plain_data_zero = (result.out_payload == '0) && (result.out_src1 == '0)
                             && (result.out_src2 == '0) && (result.out_rob_index == '0);

    // a scan run streams without gaps until its last result
    `RSTAB_NEXT(a_scan_run, result_valid && !result.last, result_valid)
    `RSTAB_HOLDS(a_entry_no_success, result_valid && result.entry_valid, !result.success)
    `RSTAB_HOLDS(a_plain_is_last, result_valid && !result.entry_valid, result.last)
    `RSTAB_HOLDS(a_plain_zero_data, result_valid && !result.entry_valid, plain_data_zero)

endmodule

bind reservation_station_table rstab_checker u_rstab_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result       (result)
);
